>>> design/spat_pkg.sv
// Shared types, codes and constants of the segment and page address translator.
package spat_pkg;

   localparam int DEF_GLOBAL_DEPTH = 256;
   localparam int DEF_LOCAL_DEPTH  = 256;
   localparam int DIR_DEPTH        = 1024;
   localparam int PAGE_DEPTH       = 1024;
   localparam int PAGE_AW          = 10;
   localparam int PAGE_ENTRY_W     = 21;
   localparam int INDEX_W          = 13;

   // Request kinds.
   typedef enum logic [2:0] {
      KIND_TRANSLATE = 3'd0,
      KIND_WR_GLOBAL = 3'd1,
      KIND_WR_LOCAL  = 3'd2,
      KIND_WR_DIR    = 3'd3,
      KIND_WR_PAGE   = 3'd4
   } kind_type;

   // Operations of the shared adder.
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DESC,
      ST_ADD,
      ST_PAGE,
      ST_DONE
   } state_type;

   // Address width of a table; a single-entry table still gets one address bit.
   function automatic int addr_width(input int depth);
      addr_width = (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

>>> design/spat_if.sv
// Valid/ready channel interfaces for translator requests and responses.
interface spat_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] seg_offset;
   logic [15:0] segment_selector;
   logic [12:0] entry_index;
   logic [63:0] entry_value;

   modport source (output valid, kind, seg_offset, segment_selector, entry_index,
                   entry_value, input ready);
   modport sink   (input valid, kind, seg_offset, segment_selector, entry_index,
                   entry_value, output ready);
endinterface

interface spat_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] phys_addr;
   logic        fault;

   modport source (output valid, phys_addr, fault, input ready);
   modport sink   (input valid, phys_addr, fault, output ready);
endinterface

>>> design/segment_page_address_translator.sv
// Top level: segment and page address translator with its sequencer.
//
//   Channel | Dir | Moves                          | Handshake
//   --------+-----+--------------------------------+-----------------
//   req     | in  | translate or table write       | valid and ready
//   rsp     | out | physical address and fault     | valid and ready
//
// A table write is accepted and written at the same edge. A translate request
// issues its descriptor read at the accepting edge and then passes through the
// limit check, the base addition with the directory and page reads, the page
// check, and the load of the output register. No new request is taken until
// that load. A bad selector goes straight to the load, a missing descriptor
// or a limit violation goes to it from the limit check. The one shared adder
// and the registered table reads set this order of steps.
// After reset a clearing pass writes zero to every table entry, one entry per
// cycle, sweeping the largest of the two descriptor depths and 1024 entries; no
// request is taken meanwhile. A finished translate waits in its final state
// while the output register holds an unaccepted response. A stalled response
// holds in the output register while further table writes are still accepted.
module segment_page_address_translator #(
   parameter int GLOBAL_TABLE_DEPTH = spat_pkg::DEF_GLOBAL_DEPTH,
   parameter int LOCAL_TABLE_DEPTH  = spat_pkg::DEF_LOCAL_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   spat_req_if.sink    req,
   spat_rsp_if.source  rsp
);

   localparam int GAW = spat_pkg::addr_width(GLOBAL_TABLE_DEPTH);
   localparam int LAW = spat_pkg::addr_width(LOCAL_TABLE_DEPTH);
   localparam int DESC_MAX = (GLOBAL_TABLE_DEPTH > LOCAL_TABLE_DEPTH) ?
                             GLOBAL_TABLE_DEPTH : LOCAL_TABLE_DEPTH;
   localparam int CLEAR_DEPTH = (DESC_MAX > spat_pkg::DIR_DEPTH) ?
                                DESC_MAX : spat_pkg::DIR_DEPTH;
   localparam int CW = $clog2(CLEAR_DEPTH);
   localparam int IW = spat_pkg::INDEX_W;
   localparam int PW = spat_pkg::PAGE_AW;

   // Sequencer and datapath registers.
   spat_pkg::state_type state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [31:0]   offset_ff, offset_in;
   logic          local_ff, local_in;
   logic [11:0]   low12_ff, low12_in;
   logic [31:0]   res_addr_ff, res_addr_in;
   logic          res_fault_ff, res_fault_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_addr_ff, rsp_addr_in;
   logic          rsp_fault_ff, rsp_fault_in;

   logic          accept;
   logic          clearing;
   logic [IW-1:0] sel_index;
   logic          sel_local;
   logic          sel_ok;

   // Table ports.
   logic          g_we, l_we, d_we, p_we;
   logic          g_wr_hit, l_wr_hit, d_wr_hit, p_wr_hit;
   logic [GAW-1:0] g_waddr;
   logic [LAW-1:0] l_waddr;
   logic [PW-1:0]  dp_waddr;
   logic [63:0]   desc_wdata;
   logic          d_wdata;
   logic [spat_pkg::PAGE_ENTRY_W-1:0] p_wdata;
   logic          desc_re, page_re;
   logic [63:0]   g_rdata, l_rdata, desc;
   logic          d_rdata;
   logic [spat_pkg::PAGE_ENTRY_W-1:0] p_rdata;

   // Shared adder.
   spat_pkg::alu_op_type alu_op;
   logic [31:0]   alu_a, alu_b, alu_sum;
   logic          alu_carry;

   // Descriptor fields.
   logic [19:0]   raw_limit;
   logic [31:0]   eff_limit;
   logic [31:0]   seg_base;
   logic          seg_present;

   assign accept    = req.valid && req.ready;
   assign clearing  = (state_ff == spat_pkg::ST_CLEAR);
   assign req.ready = (state_ff == spat_pkg::ST_IDLE);

   assign sel_index = req.segment_selector[15:3];
   assign sel_local = req.segment_selector[2];
   // A null global selector and any index past its table fault at once.
   assign sel_ok = sel_local ? ({1'b0, sel_index} < (IW + 1)'(LOCAL_TABLE_DEPTH)) :
                   ((sel_index != '0) &&
                    ({1'b0, sel_index} < (IW + 1)'(GLOBAL_TABLE_DEPTH)));

   // Write decode; writes past a table's depth are dropped.
   always_comb begin
      g_wr_hit = 1'b0;
      l_wr_hit = 1'b0;
      d_wr_hit = 1'b0;
      p_wr_hit = 1'b0;
      if (accept) begin
         unique case (req.kind)
            spat_pkg::KIND_WR_GLOBAL:
               g_wr_hit = ({1'b0, req.entry_index} < (IW + 1)'(GLOBAL_TABLE_DEPTH));
            spat_pkg::KIND_WR_LOCAL:
               l_wr_hit = ({1'b0, req.entry_index} < (IW + 1)'(LOCAL_TABLE_DEPTH));
            spat_pkg::KIND_WR_DIR:
               d_wr_hit = ({1'b0, req.entry_index} < (IW + 1)'(spat_pkg::DIR_DEPTH));
            spat_pkg::KIND_WR_PAGE:
               p_wr_hit = ({1'b0, req.entry_index} < (IW + 1)'(spat_pkg::PAGE_DEPTH));
            default: begin
            end
         endcase
      end
   end

   // During the clearing pass the sweep counter drives every write port.
   assign g_we = clearing ? ({1'b0, clr_ff} < (CW + 1)'(GLOBAL_TABLE_DEPTH)) : g_wr_hit;
   assign l_we = clearing ? ({1'b0, clr_ff} < (CW + 1)'(LOCAL_TABLE_DEPTH)) : l_wr_hit;
   assign d_we = clearing ? ({1'b0, clr_ff} < (CW + 1)'(spat_pkg::DIR_DEPTH)) : d_wr_hit;
   assign p_we = clearing ? ({1'b0, clr_ff} < (CW + 1)'(spat_pkg::PAGE_DEPTH)) : p_wr_hit;

   assign g_waddr  = clearing ? clr_ff[GAW-1:0] : req.entry_index[GAW-1:0];
   assign l_waddr  = clearing ? clr_ff[LAW-1:0] : req.entry_index[LAW-1:0];
   assign dp_waddr = clearing ? clr_ff[PW-1:0]  : req.entry_index[PW-1:0];

   assign desc_wdata = clearing ? 64'd0 : req.entry_value;
   assign d_wdata    = clearing ? 1'b0  : req.entry_value[0];
   // A page entry keeps the frame above its present bit.
   assign p_wdata    = clearing ? '0 : {req.entry_value[31:12], req.entry_value[0]};

   assign desc_re = accept && (req.kind == spat_pkg::KIND_TRANSLATE) && sel_ok;
   assign page_re = (state_ff == spat_pkg::ST_ADD);

   spat_ram #(.DEPTH(GLOBAL_TABLE_DEPTH), .WIDTH(64)) u_global (
      .clock   (clock),
      .wr_en   (g_we),
      .wr_addr (g_waddr),
      .wr_data (desc_wdata),
      .rd_en   (desc_re),
      .rd_addr (sel_index[GAW-1:0]),
      .rd_data (g_rdata)
   );

   spat_ram #(.DEPTH(LOCAL_TABLE_DEPTH), .WIDTH(64)) u_local (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (desc_wdata),
      .rd_en   (desc_re),
      .rd_addr (sel_index[LAW-1:0]),
      .rd_data (l_rdata)
   );

   spat_ram #(.DEPTH(spat_pkg::DIR_DEPTH), .WIDTH(1)) u_dir (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (dp_waddr),
      .wr_data (d_wdata),
      .rd_en   (page_re),
      .rd_addr (alu_sum[31:22]),
      .rd_data (d_rdata)
   );

   spat_ram #(.DEPTH(spat_pkg::PAGE_DEPTH), .WIDTH(spat_pkg::PAGE_ENTRY_W)) u_page (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (dp_waddr),
      .wr_data (p_wdata),
      .rd_en   (page_re),
      .rd_addr (alu_sum[21:12]),
      .rd_data (p_rdata)
   );

   // Descriptor fields, taken from whichever table the selector named.
   assign desc        = local_ff ? l_rdata : g_rdata;
   assign seg_present = desc[47];
   assign raw_limit   = {desc[51:48], desc[15:0]};
   assign eff_limit   = desc[55] ? {raw_limit, 12'hFFF} : {12'd0, raw_limit};
   assign seg_base    = {desc[63:56], desc[39:32], desc[31:16]};

   // The adder compares the limit with the offset first, then forms the
   // linear address from base and offset.
   assign alu_op = (state_ff == spat_pkg::ST_DESC) ? spat_pkg::ALU_SUB : spat_pkg::ALU_ADD;
   assign alu_a  = (state_ff == spat_pkg::ST_DESC) ? eff_limit : seg_base;
   assign alu_b  = offset_ff;

   spat_alu u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spat_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff    <= offset_in;
      local_ff     <= local_in;
      low12_ff     <= low12_in;
      res_addr_ff  <= res_addr_in;
      res_fault_ff <= res_fault_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      offset_in    = offset_ff;
      local_in     = local_ff;
      low12_in     = low12_ff;
      res_addr_in  = res_addr_ff;
      res_fault_in = res_fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_fault_in = rsp_fault_ff;

      unique case (state_ff)
         spat_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(CLEAR_DEPTH - 1)) begin
               state_in = spat_pkg::ST_IDLE;
            end
         end
         spat_pkg::ST_IDLE: begin
            if (accept && (req.kind == spat_pkg::KIND_TRANSLATE)) begin
               offset_in = req.seg_offset;
               local_in  = sel_local;
               if (sel_ok) begin
                  state_in = spat_pkg::ST_DESC;
               end else begin
                  res_addr_in  = 32'd0;
                  res_fault_in = 1'b1;
                  state_in     = spat_pkg::ST_DONE;
               end
            end
         end
         spat_pkg::ST_DESC: begin
            // The carry is clear when the offset lies above the limit.
            if (!seg_present || !alu_carry) begin
               res_addr_in  = 32'd0;
               res_fault_in = 1'b1;
               state_in     = spat_pkg::ST_DONE;
            end else begin
               state_in = spat_pkg::ST_ADD;
            end
         end
         spat_pkg::ST_ADD: begin
            low12_in = alu_sum[11:0];
            state_in = spat_pkg::ST_PAGE;
         end
         spat_pkg::ST_PAGE: begin
            if (!d_rdata || !p_rdata[0]) begin
               res_addr_in  = 32'd0;
               res_fault_in = 1'b1;
            end else begin
               res_addr_in  = {p_rdata[20:1], low12_ff};
               res_fault_in = 1'b0;
            end
            state_in = spat_pkg::ST_DONE;
         end
         spat_pkg::ST_DONE: begin
            // Wait here until the output register is free.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_fault_in = res_fault_ff;
               state_in     = spat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spat_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.phys_addr = rsp_addr_ff;
   assign rsp.fault     = rsp_fault_ff;

   // A faulting response always carries a zero address.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fault_ff) |-> (rsp_addr_ff == 32'd0))
      else $error("faulting response with nonzero address");

   // A new response is loaded only out of the final sequencer state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp.ready)) |->
      ($past(state_ff) == spat_pkg::ST_DONE))
      else $error("response loaded outside the final state");

   // An accepted translate either reads its descriptor or faults at once.
   a_translate_next: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.kind == spat_pkg::KIND_TRANSLATE)) |=>
      ((state_ff == spat_pkg::ST_DESC) || (state_ff == spat_pkg::ST_DONE)))
      else $error("translate request took a wrong sequencer path");

   // No descriptor or page read is issued while the tables are still being cleared.
   a_no_read_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!desc_re && !page_re))
      else $error("table read during the clearing pass");

endmodule

>>> design/spat_ram.sv
// Single-port-write, single-port-read table memory with a registered read.
module spat_ram #(
   parameter int DEPTH = spat_pkg::DEF_GLOBAL_DEPTH,
   parameter int WIDTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [spat_pkg::addr_width(DEPTH)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [spat_pkg::addr_width(DEPTH)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/spat_alu.sv
// Shared 32-bit adder used for the limit check and the base addition.
module spat_alu (
   input  spat_pkg::alu_op_type op,
   input  logic [31:0]          a,
   input  logic [31:0]          b,
   output logic [31:0]          sum,
   output logic                 carry
);

   logic        sub;
   logic [32:0] total;

   assign sub   = (op == spat_pkg::ALU_SUB);
   // In subtract mode the carry out is set exactly when a >= b.
   assign total = {1'b0, a} + {1'b0, b ^ {32{sub}}} + 33'(sub);
   assign sum   = total[31:0];
   assign carry = total[32];

endmodule

>>> sim/translation_checker.sv
// Checker for the translator: tracks table contents and compares every response in order.
module translation_checker #(
   parameter int GLOBAL_DEPTH = spat_pkg::DEF_GLOBAL_DEPTH,
   parameter int LOCAL_DEPTH  = spat_pkg::DEF_LOCAL_DEPTH
) (
   input  logic clock,
   input  logic reset,
   spat_req_if  req,
   spat_rsp_if  rsp,
   output int   error_count,
   output int   pending_count,
   output int   checked_count,
   output int   fault_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GAW = spat_pkg::addr_width(GLOBAL_DEPTH);
   localparam int LAW = spat_pkg::addr_width(LOCAL_DEPTH);
   localparam int PW  = spat_pkg::PAGE_AW;

   typedef struct packed {
      logic [31:0] phys;
      logic        fault;
   } translation_type;

   logic [63:0]                       global_tbl [GLOBAL_DEPTH];
   logic [63:0]                       local_tbl  [LOCAL_DEPTH];
   logic                              dir_map    [spat_pkg::DIR_DEPTH];
   logic [spat_pkg::PAGE_ENTRY_W-1:0] page_tbl   [spat_pkg::PAGE_DEPTH];
   translation_type                   expected_translations [$];
   int                                mismatches;
   int                                checked;
   int                                faults;

   task automatic report_mismatch(input string msg);
      if (mismatches < 30) begin
         $display("translation_checker: %0t ns: %s", $time, msg);
      end
      mismatches++;
   endtask

   // Expected outcome of one translate request against the current tables.
   function automatic translation_type translate_address(input logic [31:0] offset,
                                                         input logic [15:0] sel);
      translation_type                   res;
      logic [12:0]                       idx;
      logic [63:0]                       desc;
      logic [31:0]                       seg_base;
      logic [31:0]                       seg_limit;
      logic [31:0]                       linear;
      logic [spat_pkg::PAGE_ENTRY_W-1:0] pte;
      res.phys  = '0;
      res.fault = 1'b1;
      idx = sel[15:3];
      if (sel[2]) begin
         if (idx >= LOCAL_DEPTH) return res;
         desc = local_tbl[idx[LAW-1:0]];
      end else begin
         if (idx == 0 || idx >= GLOBAL_DEPTH) return res;
         desc = global_tbl[idx[GAW-1:0]];
      end
      if (!desc[47]) return res;
      seg_limit = desc[55] ? {desc[51:48], desc[15:0], 12'hFFF}
                           : {12'h000, desc[51:48], desc[15:0]};
      if (offset > seg_limit) return res;
      seg_base = {desc[63:56], desc[39:32], desc[31:16]};
      linear   = seg_base + offset;
      if (!dir_map[linear[31:22]]) return res;
      pte = page_tbl[linear[21:12]];
      if (!pte[0]) return res;
      res.phys  = {pte[20:1], linear[11:0]};
      res.fault = 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin
      translation_type want;
      if (reset) begin
         for (int i = 0; i < GLOBAL_DEPTH; i++) global_tbl[i] = '0;
         for (int i = 0; i < LOCAL_DEPTH; i++) local_tbl[i] = '0;
         for (int i = 0; i < spat_pkg::DIR_DEPTH; i++) dir_map[i] = 1'b0;
         for (int i = 0; i < spat_pkg::PAGE_DEPTH; i++) page_tbl[i] = '0;
         expected_translations.delete();
      end else begin
         // A response always belongs to an earlier translate, so compare first.
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (expected_translations.size() == 0) begin
               report_mismatch($sformatf("response with nothing expected: addr %h fault %b",
                                         rsp.phys_addr, rsp.fault));
            end else begin
               want = expected_translations.pop_front();
               checked++;
               if (want.fault) faults++;
               if (rsp.phys_addr !== want.phys) begin
                  report_mismatch($sformatf("phys_addr %h, expected %h",
                                            rsp.phys_addr, want.phys));
               end
               if (rsp.fault !== want.fault) begin
                  report_mismatch($sformatf("fault %b, expected %b", rsp.fault, want.fault));
               end
            end
         end
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            case (req.kind)
               spat_pkg::KIND_TRANSLATE: begin
                  expected_translations.insert(expected_translations.size(),
                     translate_address(req.seg_offset, req.segment_selector));
               end
               spat_pkg::KIND_WR_GLOBAL: begin
                  if (req.entry_index < GLOBAL_DEPTH) begin
                     global_tbl[req.entry_index[GAW-1:0]] = req.entry_value;
                  end
               end
               spat_pkg::KIND_WR_LOCAL: begin
                  if (req.entry_index < LOCAL_DEPTH) begin
                     local_tbl[req.entry_index[LAW-1:0]] = req.entry_value;
                  end
               end
               spat_pkg::KIND_WR_DIR: begin
                  if (req.entry_index < spat_pkg::DIR_DEPTH) begin
                     dir_map[req.entry_index[PW-1:0]] = req.entry_value[0];
                  end
               end
               spat_pkg::KIND_WR_PAGE: begin
                  if (req.entry_index < spat_pkg::PAGE_DEPTH) begin
                     page_tbl[req.entry_index[PW-1:0]] =
                        {req.entry_value[31:12], req.entry_value[0]};
                  end
               end
               default: ;
            endcase
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_translations.size();
      checked_count <= checked;
      fault_count   <= faults;
   end

endmodule

>>> sim/tb_top.sv
// Testbench top: drives requests, paces responses and reports the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GLOBAL_DEPTH = spat_pkg::DEF_GLOBAL_DEPTH;
   localparam int LOCAL_DEPTH  = spat_pkg::DEF_LOCAL_DEPTH;
   // Requests the block acts on that the random phase sends before it counts as done.
   localparam int RANDOM_REQUESTS = 935;
   // Far above the slowest legal run: the clearing pass, about 1050 requests
   // each with a full sender gap, the walk through the sequencer and a slow
   // receiver, plus the long receiver hold-off.
   localparam int CYCLE_LIMIT = 400_000;
   localparam int HOLD_OFF_CYCLES = 300;
   // Request kinds with no defined action; the block must ignore them.
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

   logic clock;
   logic reset;

   spat_req_if req ();
   spat_rsp_if rsp ();

   int error_count;
   int pending_count;
   int checked_count;
   int fault_count;
   int sent_count;
   int cycles;
   bit hold_off_request;
   bit hold_off_done;

   // Hot directory and page indices. Most random descriptors put their base
   // inside one of these, and most directory and page writes land on them, so
   // that a good share of translations walk all the way to a frame.
   logic [9:0]  hot_dirs  [8];
   logic [9:0]  hot_pages [16];
   // Effective limits of the low descriptor entries, as written, so that
   // offsets can be aimed right at the limit edge.
   logic [31:0] global_limit [16];
   logic [31:0] local_limit  [16];

   segment_page_address_translator #(
      .GLOBAL_TABLE_DEPTH(GLOBAL_DEPTH),
      .LOCAL_TABLE_DEPTH (LOCAL_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp)
   );

   translation_checker #(
      .GLOBAL_DEPTH(GLOBAL_DEPTH),
      .LOCAL_DEPTH (LOCAL_DEPTH)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .error_count  (error_count),
      .pending_count(pending_count),
      .checked_count(checked_count),
      .fault_count  (fault_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. A hung handshake ends the run here as a failure.
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top: no finish after %0d cycles, %0d responses still owed",
               CYCLE_LIMIT, pending_count);
      $display("tb_top: done, errors");
      $finish;
   end

   // Offers one request and holds it until the block takes it. The request
   // is accepted at the edge where this task returns; the caller then either
   // offers the next one at once or drops valid for a gap.
   task automatic send_request(input logic [2:0]  kind,
                               input logic [31:0] offset,
                               input logic [15:0] sel,
                               input logic [12:0] idx,
                               input logic [63:0] value);
      req.valid            <= 1'b1;
      req.kind             <= kind;
      req.seg_offset       <= offset;
      req.segment_selector <= sel;
      req.entry_index      <= idx;
      req.entry_value      <= value;
      @(posedge clock);
      while (req.ready !== 1'b1) @(posedge clock);
      sent_count++;
   endtask

   // Drops valid for the given gap. The payload is scrambled meanwhile,
   // since the block must not look at it without valid.
   task automatic idle_sender(input int gap);
      req.valid            <= 1'b0;
      req.kind             <= 3'($urandom);
      req.seg_offset       <= $urandom;
      req.segment_selector <= 16'($urandom);
      req.entry_index      <= 13'($urandom);
      req.entry_value      <= {$urandom, $urandom};
      repeat (gap) @(posedge clock);
   endtask

   // A descriptor with the given base, raw limit, granularity and present
   // bit. The bits the translator does not use are random.
   function automatic logic [63:0] build_descriptor(input logic [31:0] base,
                                                    input logic [19:0] limit,
                                                    input logic        gran,
                                                    input logic        present);
      logic [63:0] d;
      d = {$urandom, $urandom};
      d[63:56] = base[31:24];
      d[39:32] = base[23:16];
      d[31:16] = base[15:0];
      d[51:48] = limit[19:16];
      d[15:0]  = limit[15:0];
      d[55]    = gran;
      d[47]    = present;
      return d;
   endfunction

   // Receiver. It changes its pacing after each span of random length: always
   // ready, ready at random, or ready only now and then. Once, on request from the
   // stimulus, it holds ready low for a long stretch so that a response
   // sits in the output register and the block backs up into its input.
   initial begin
      int mode;
      int span;
      rsp.ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_request && !hold_off_done) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            mode = $urandom_range(2);
            span = $urandom_range(10, 80);
            repeat (span) begin
               case (mode)
                  0:       rsp.ready <= 1'b1;
                  1:       rsp.ready <= 1'($urandom_range(1));
                  default: rsp.ready <= ($urandom_range(3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Stimulus: reset, a directed walk through the corner cases, then random
   // traffic shaped around the hot directory and page indices.
   initial begin
      logic [2:0]  kind;
      logic [31:0] offset;
      logic [15:0] sel;
      logic [12:0] idx;
      logic [63:0] value;
      logic [31:0] base;
      logic [19:0] limit;
      logic        gran;
      logic        table_bit;
      int          useful;
      int          burst_left;
      int          pick;
      int          gap;

      req.valid            = 1'b0;
      req.kind             = spat_pkg::KIND_TRANSLATE;
      req.seg_offset       = '0;
      req.segment_selector = '0;
      req.entry_index      = '0;
      req.entry_value      = '0;
      sent_count           = 0;
      hold_off_request     = 1'b0;
      hold_off_done        = 1'b0;
      for (int i = 0; i < 16; i++) begin
         global_limit[i] = '0;
         local_limit[i]  = '0;
      end
      for (int i = 0; i < 8; i++) hot_dirs[i] = 10'($urandom);
      for (int i = 0; i < 16; i++) hot_pages[i] = 10'($urandom);
      // Keep directory 0 and page 0x12 among the hot ones, the directed
      // part sets them up.
      hot_dirs[0]  = 10'h000;
      hot_pages[0] = 10'h012;

      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- Directed part -------------------------------------------------
      // Null global selector, with and without the privilege bits set.
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0000_0000, 16'h0000, '0, '0);
      send_request(spat_pkg::KIND_TRANSLATE, 32'hFFFF_FFFF, 16'h0003, '0, '0);
      // Selector index beyond the global and the local table.
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0000_0000, 16'h0808, '0, '0);
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0000_0000, 16'hFFFC, '0, '0);
      // Global entry 1 is still not present after the clearing pass.
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0001_2345, 16'h0008, '0, '0);
      // Flat 4 GB segment at global entry 1, page granular.
      send_request(spat_pkg::KIND_WR_GLOBAL, '0, '0, 13'd1,
                   build_descriptor(32'h0000_0000, 20'hF_FFFF, 1'b1, 1'b1));
      // Directory entry 0 not yet present.
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0001_2345, 16'h000B, '0, '0);
      send_request(spat_pkg::KIND_WR_DIR, '0, '0, 13'd0, 64'h0000_0000_0000_0001);
      // Page entry 0x12 not yet present.
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0001_2345, 16'h0008, '0, '0);
      send_request(spat_pkg::KIND_WR_PAGE, '0, '0, 13'h012, 64'hFFFF_FFFF_ABCD_E001);
      // Full walk succeeds.
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0001_2345, 16'h0008, '0, '0);
      // Top of the 4 GB segment: the limit check passes, directory 1023 is
      // not present.
      send_request(spat_pkg::KIND_TRANSLATE, 32'hFFFF_FFFF, 16'h0008, '0, '0);
      // Local index zero is a real entry: byte granular, limit 0x3000.
      send_request(spat_pkg::KIND_WR_LOCAL, '0, '0, 13'd0,
                   build_descriptor(32'h0001_0000, 20'h0_3000, 1'b0, 1'b1));
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0000_2345, 16'h0004, '0, '0);
      // Offset right at the limit passes, one above it faults.
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0000_3000, 16'h0007, '0, '0);
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0000_3001, 16'h0004, '0, '0);
      // Base plus offset wraps around 2^32 onto the same page.
      send_request(spat_pkg::KIND_WR_GLOBAL, '0, '0, 13'd2,
                   build_descriptor(32'hFFFF_F000, 20'hF_FFFF, 1'b1, 1'b1));
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0001_3345, 16'h0010, '0, '0);
      // Writes past the end of each table must change nothing. The
      // directory and page ones would alias onto live entries if the block
      // dropped the upper index bits.
      send_request(spat_pkg::KIND_WR_GLOBAL, '0, '0, 13'd256, '1);
      send_request(spat_pkg::KIND_WR_LOCAL, '0, '0, 13'h1FFF, '1);
      send_request(spat_pkg::KIND_WR_DIR, '0, '0, 13'd1024, 64'h0000_0000_0000_0000);
      send_request(spat_pkg::KIND_WR_PAGE, '0, '0, 13'h412, 64'h0000_0000_0000_0000);
      // Spare kinds are dropped without a response.
      send_request(KIND_SPARE_FIRST, '1, 16'h0008, 13'd1, '0);
      send_request(3'(KIND_SPARE_FIRST + 3'd1), 32'h0001_2345, 16'h0008, 13'h012, '1);
      send_request(KIND_SPARE_LAST, '1, '1, '1, '1);
      // The first walk must still give the same frame.
      send_request(spat_pkg::KIND_TRANSLATE, 32'h0001_2345, 16'h0008, '0, '0);

      // --- Random part ---------------------------------------------------
      useful     = 0;
      burst_left = 0;
      while (useful < RANDOM_REQUESTS) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) idle_sender(gap);
         end
         burst_left--;
         if (useful == 300) hold_off_request = 1'b1;

         offset = $urandom;
         sel    = 16'($urandom);
         idx    = 13'($urandom);
         value  = {$urandom, $urandom};
         pick   = $urandom_range(99);

         if (pick < 45) begin
            kind = spat_pkg::KIND_TRANSLATE;
            table_bit = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 80) idx = 13'($urandom_range(15));
            else if (pick < 90) idx = 13'($urandom_range(8191));
            else idx = 13'($urandom_range(GLOBAL_DEPTH - 2, GLOBAL_DEPTH + 1));
            sel  = {idx, table_bit, 2'($urandom)};
            pick = $urandom_range(99);
            if (pick < 40) begin
               offset = $urandom_range(32'h0000_0FFF);
            end else if (pick < 60) begin
               offset = $urandom_range(32'h003F_FFFF);
            end else if (pick < 75) begin
               offset = $urandom;
            end else if (pick < 90 && idx < 16) begin
               // Just below, at or just above the limit.
               offset = (table_bit ? local_limit[idx[3:0]] : global_limit[idx[3:0]])
                        + 32'($urandom_range(2)) - 32'd1;
            end else begin
               case ($urandom_range(4))
                  0:       offset = 32'h0000_0000;
                  1:       offset = 32'h0000_0FFF;
                  2:       offset = 32'h0000_1000;
                  3:       offset = 32'h000F_FFFF;
                  default: offset = 32'hFFFF_FFFF;
               endcase
            end
         end else if (pick < 65) begin
            kind = (pick < 55) ? spat_pkg::KIND_WR_GLOBAL : spat_pkg::KIND_WR_LOCAL;
            pick = $urandom_range(99);
            if (pick < 80) idx = 13'($urandom_range(15));
            else if (pick < 90) idx = 13'($urandom_range(8191));
            else idx = 13'($urandom_range(GLOBAL_DEPTH - 6, GLOBAL_DEPTH + 4));
            gran  = ($urandom_range(99) < 60);
            limit = ($urandom_range(1) == 0) ? 20'hF_FFFF : 20'($urandom);
            if ($urandom_range(99) < 70) begin
               base = {hot_dirs[3'($urandom_range(7))], hot_pages[4'($urandom_range(15))],
                       12'($urandom)};
            end else begin
               base = $urandom;
            end
            value = build_descriptor(base, limit, gran, ($urandom_range(99) < 90));
            if (idx < 16) begin
               if (kind == spat_pkg::KIND_WR_GLOBAL) begin
                  global_limit[idx[3:0]] = gran ? {limit, 12'hFFF} : {12'h000, limit};
               end else begin
                  local_limit[idx[3:0]] = gran ? {limit, 12'hFFF} : {12'h000, limit};
               end
            end
         end else if (pick < 77) begin
            kind = spat_pkg::KIND_WR_DIR;
            pick = $urandom_range(99);
            if (pick < 70) begin
               idx = 13'(hot_dirs[3'($urandom_range(7))]) + 13'($urandom_range(1));
            end else if (pick < 90) begin
               idx = 13'($urandom_range(spat_pkg::DIR_DEPTH - 1));
            end else begin
               idx = 13'($urandom_range(8191));
            end
            value[0] = ($urandom_range(99) < 85);
         end else if (pick < 97) begin
            kind = spat_pkg::KIND_WR_PAGE;
            pick = $urandom_range(99);
            if (pick < 70) begin
               idx = 13'(hot_pages[4'($urandom_range(15))]) + 13'($urandom_range(1));
            end else if (pick < 90) begin
               idx = 13'($urandom_range(spat_pkg::PAGE_DEPTH - 1));
            end else begin
               idx = 13'($urandom_range(8191));
            end
            value[0] = ($urandom_range(99) < 85);
         end else begin
            kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
         end

         send_request(kind, offset, sel, idx, value);

         // Only requests the block acts on move the count along.
         case (kind)
            spat_pkg::KIND_TRANSLATE: useful++;
            spat_pkg::KIND_WR_GLOBAL: if (idx < GLOBAL_DEPTH) useful++;
            spat_pkg::KIND_WR_LOCAL:  if (idx < LOCAL_DEPTH) useful++;
            spat_pkg::KIND_WR_DIR:    if (idx < spat_pkg::DIR_DEPTH) useful++;
            spat_pkg::KIND_WR_PAGE:   if (idx < spat_pkg::PAGE_DEPTH) useful++;
            default: ;
         endcase
      end

      // Drain. The checker's counts are registered, so step once before looking
      // at them, then give the pipeline time to show any stray response.
      idle_sender(1);
      while (pending_count != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("tb_top: %0d requests sent, %0d translations checked, %0d of them faults",
               sent_count, checked_count, fault_count);
      $display("tb_top: %0d mismatches over %0d cycles", error_count, cycles);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
